/* design/asm_pkg.sv */
package asm_pkg;

    localparam int MAX_BANDS_DEF   = 64;
    localparam int NUM_BOOKS       = 12;
    localparam int BOOK_FIELD_BITS = 4;

    localparam int CNT_W  = 15;
    localparam int BITS_W = 16;
    localparam int GAIN_W = 17;
    localparam int LEN_W  = 7;
    localparam int BOOK_W = 4;
    localparam int SIDE_W = 8;
    localparam int BAND_W = 6;
    localparam int SUM_W  = 8;
    localparam int CFG_W  = 15;
    localparam int OUT_W  = 40;

    localparam logic [BOOK_W-1:0] LAST_BOOK = BOOK_W'(NUM_BOOKS - 1);

    // side info segment sizes and escapes
    localparam int SEG_SHORT = 3;
    localparam int SEG_LONG  = 5;
    localparam int ESC_SHORT = 7;
    localparam int ESC_LONG  = 31;
    // len / esc as (len * RECIP) >> SHIFT, exact for len up to 64
    localparam int RECIP_SHORT = 37;
    localparam int SHIFT_SHORT = 8;
    localparam int RECIP_LONG  = 265;
    localparam int SHIFT_LONG  = 13;

    localparam logic [1:0] CFG_BAND_COUNT = 2'd0;
    localparam logic [1:0] CFG_SHORT_BLK  = 2'd1;
    localparam logic [1:0] CFG_INVALID    = 2'd2;

    typedef logic [NUM_BOOKS-1:0][CNT_W-1:0]  row_t;
    typedef logic [NUM_BOOKS-1:0][BITS_W-1:0] sum_row_t;

    typedef struct packed {
        logic [BITS_W-1:0] val;
        logic [BOOK_W-1:0] book;
    } pick_t;

    typedef struct packed {
        logic              en;
        logic [BAND_W-1:0] band;
        logic [BOOK_W-1:0] book;
        logic [CNT_W-1:0]  cnt;
    } tbl_wr_t;

    typedef struct packed {
        logic [LEN_W-1:0] band_count;
        logic             short_blk;
        logic [CNT_W-1:0] invalid_bitcount;
    } cfg_t;

    function automatic logic [SIDE_W-1:0] side_bits(input logic [LEN_W-1:0] len,
                                                    input logic short_win);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [SIDE_W-1:0] res;
        if (short_win) begin
            prod = 16'(len) * 16'(RECIP_SHORT);
            q    = 4'(prod >> SHIFT_SHORT);
            res  = SIDE_W'(BOOK_FIELD_BITS) + SIDE_W'(SEG_SHORT) * (SIDE_W'(q) + SIDE_W'(1));
        end else begin
            prod = 16'(len) * 16'(RECIP_LONG);
            q    = 4'(prod >> SHIFT_LONG);
            res  = SIDE_W'(BOOK_FIELD_BITS) + SIDE_W'(SEG_LONG) * (SIDE_W'(q) + SIDE_W'(1));
        end
        return res;
    endfunction

    function automatic pick_t pick_min(input pick_t lo, input pick_t hi);
        return (hi.val < lo.val) ? hi : lo;
    endfunction

    // cheapest book, lowest index on ties; none below limit gives the last book
    function automatic pick_t best_of(input sum_row_t row, input logic [BITS_W-1:0] limit);
        pick_t l1 [6];
        pick_t l2 [3];
        pick_t top;
        pick_t res;
        for (int k = 0; k < 6; k++) begin
            l1[k] = pick_min('{val: row[2*k],   book: BOOK_W'(2*k)},
                             '{val: row[2*k+1], book: BOOK_W'(2*k+1)});
        end
        for (int k = 0; k < 3; k++) begin
            l2[k] = pick_min(l1[2*k], l1[2*k+1]);
        end
        top = pick_min(pick_min(l2[0], l2[1]), l2[2]);
        if (top.val < limit) begin
            res = top;
        end else begin
            res = '{val: limit, book: LAST_BOOK};
        end
        return res;
    endfunction

    function automatic sum_row_t widen(input row_t row);
        sum_row_t r;
        for (int j = 0; j < NUM_BOOKS; j++) begin
            r[j] = BITS_W'(row[j]);
        end
        return r;
    endfunction

endpackage

/* design/aac_section_merge.sv */
// Greedy section merge for one group of scale factor bands. Bit count words
// load into the per-band codebook table one per cycle; the word with tlast
// starts sectioning and the input then stalls until the last section word has
// been placed in the output register. Sectioning first takes the cheapest book
// of each band and builds runs of equal books, then seeds the merge gains of
// each section, then each merge round scans the section chain (one read of the
// section memory per hop), merges the winning pair and refreshes the two
// neighboring gains. Results leave one section word at a time, held in the
// output register while the output side is stalled. The section and work-row
// memories both have registered reads.
module aac_section_merge import asm_pkg::*; #(
    parameter int MAX_BANDS = MAX_BANDS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,    // band[5:0], book[9:6], bit_count[24:10]
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,    // section_start[5:0], section_length[12:6],
                                         // codebook[16:13], huff_bits[31:17],
                                         // side_bits[39:32]
    output logic             m_tlast,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(MAX_BANDS);

    cfg_t          cfg_reg;
    tbl_wr_t       tbl_wr;
    logic [AW-1:0] tbl_raddr;
    row_t          tbl_rdata;
    logic          load_ready;
    logic          s_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.band_count       <= LEN_W'(49);
            cfg_reg.short_blk        <= 1'b0;
            cfg_reg.invalid_bitcount <= CNT_W'(16383);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BAND_COUNT: cfg_reg.band_count       <= cfg_wdata[LEN_W-1:0];
                CFG_SHORT_BLK:  cfg_reg.short_blk        <= cfg_wdata[0];
                CFG_INVALID:    cfg_reg.invalid_bitcount <= cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = load_ready && aresetn;
    assign s_accept = s_tvalid && s_tready;

    assign tbl_wr = '{en:   s_accept,
                      band: s_tdata[5:0],
                      book: s_tdata[9:6],
                      cnt:  s_tdata[24:10]};

    asm_bit_table #(.MAX_BANDS(MAX_BANDS)) u_table (
        .aclk  (aclk),
        .wr    (tbl_wr),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    asm_core #(.MAX_BANDS(MAX_BANDS)) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .load_last  (s_accept && s_tlast),
        .load_ready (load_ready),
        .tbl_raddr  (tbl_raddr),
        .tbl_rdata  (tbl_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

/* design/asm_bit_table.sv */
module asm_bit_table import asm_pkg::*; #(
    parameter int MAX_BANDS = MAX_BANDS_DEF,
    localparam int AW = $clog2(MAX_BANDS)
) (
    input  logic          aclk,
    input  tbl_wr_t       wr,
    input  logic [AW-1:0] raddr,
    output row_t          rdata
);

    row_t mem [MAX_BANDS];
    logic wr_ok;

    assign wr_ok = wr.en && (int'(wr.band) < MAX_BANDS) && (int'(wr.book) < NUM_BOOKS);

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr.band[AW-1:0]][wr.book] <= wr.cnt;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/asm_core.sv */
module asm_core import asm_pkg::*; #(
    parameter int MAX_BANDS = MAX_BANDS_DEF,
    localparam int AW = $clog2(MAX_BANDS),
    localparam int NW = $clog2(MAX_BANDS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             load_last,
    output logic             load_ready,
    output logic [AW-1:0]    tbl_raddr,
    input  row_t             tbl_rdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    typedef enum logic [4:0] {
        LOAD, I_RD, I_BEST, I_RUN, I_CLOSE,
        G_RD, G_CHK, G_NEXT,
        PG_RD, PG_SUM, PG_MIN, PG_GAIN,
        M_START, M_RD, M_CHK,
        X_RD, X_UPD, X_PRD, X_PWAIT, X_TAIL,
        O_RD, O_CALC, O_EMIT
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [BITS_W-1:0] bits;
        logic [GAIN_W-1:0] gain;
    } sec_t;

    // memories
    row_t            work_mem  [MAX_BANDS];
    sec_t            sec_mem   [MAX_BANDS];
    logic [AW-1:0]   start_mem [MAX_BANDS];

    logic            work_we, sec_we, start_we;
    logic [AW-1:0]   work_wa, sec_wa, start_wa;
    row_t            work_wd;
    sec_t            sec_wd;
    logic [AW-1:0]   start_wd;
    logic [AW-1:0]   work_ra0, work_ra1, sec_ra0, sec_ra1, start_ra;
    row_t            work_rd0, work_rd1;
    sec_t            sec_rd0, sec_rd1;
    logic [AW-1:0]   start_rd;

    always_ff @(posedge aclk) begin
        if (work_we) begin
            work_mem[work_wa] <= work_wd;
        end
        work_rd0 <= work_mem[work_ra0];
        work_rd1 <= work_mem[work_ra1];
    end

    always_ff @(posedge aclk) begin
        if (sec_we) begin
            sec_mem[sec_wa] <= sec_wd;
        end
        sec_rd0 <= sec_mem[sec_ra0];
        sec_rd1 <= sec_mem[sec_ra1];
    end

    always_ff @(posedge aclk) begin
        if (start_we) begin
            start_mem[start_wa] <= start_wd;
        end
        start_rd <= start_mem[start_ra];
    end

    function automatic row_t merge_row(input row_t x, input row_t y,
                                       input logic [CNT_W-1:0] lim);
        row_t r;
        logic [BITS_W-1:0] s;
        for (int j = 0; j < NUM_BOOKS; j++) begin
            s    = BITS_W'(x[j]) + BITS_W'(y[j]);
            r[j] = (s < BITS_W'(lim)) ? s[CNT_W-1:0] : lim;
        end
        return r;
    endfunction

    state_t            state_reg, state_next, ret_reg, ret_next;
    logic [NW-1:0]     n_reg, n_next, i_reg, i_next, s_reg, s_next;
    logic [NW-1:0]     a_reg, a_next, b_reg, b_next;
    logic [NW-1:0]     idx_reg, idx_next, nxt_reg, nxt_next, nxt2_reg, nxt2_next;
    logic [BOOK_W-1:0] rbook_reg, rbook_next, bb_reg, bb_next;
    logic [LEN_W-1:0]  rlen_reg, rlen_next, lensum_reg, lensum_next, idxlen_reg, idxlen_next;
    logic [BITS_W-1:0] rbits_reg, rbits_next, bv_reg, bv_next;
    row_t              acc_reg, acc_next, row_reg, row_next;
    sum_row_t          sum_reg, sum_next;
    logic [GAIN_W-1:0] bitsum_reg, bitsum_next, mside_reg, mside_next;
    logic [GAIN_W-1:0] best_reg, best_next;
    sec_t              seca_reg, seca_next;
    logic [BAND_W-1:0] o_start_reg, o_start_next;
    logic [LEN_W-1:0]  o_len_reg, o_len_next;
    logic [BOOK_W-1:0] o_book_reg, o_book_next;
    logic [CNT_W-1:0]  o_hb_reg, o_hb_next;
    logic [SIDE_W-1:0] o_side_reg, o_side_next;
    logic              o_last_reg, o_last_next;
    logic              m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    always_comb begin
        pick_t             pk;
        logic [SUM_W-1:0]  bsum;
        logic [NW-1:0]     nn;
        logic [NW-1:0]     im1;
        logic [GAIN_W-1:0] t17;
        logic signed [18:0] t19;
        logic signed [17:0] t18;
        logic [SIDE_W-1:0] sd;
        logic [LEN_W-1:0]  ln;
        logic [BITS_W-1:0] lim;

        lim  = BITS_W'(cfg.invalid_bitcount);
        pk   = '0;
        bsum = '0;
        nn   = '0;
        im1  = '0;
        t17  = '0;
        t19  = '0;
        t18  = '0;
        sd   = '0;
        ln   = '0;

        state_next   = state_reg;
        ret_next     = ret_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        s_next       = s_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        idx_next     = idx_reg;
        nxt_next     = nxt_reg;
        nxt2_next    = nxt2_reg;
        rbook_next   = rbook_reg;
        bb_next      = bb_reg;
        rlen_next    = rlen_reg;
        lensum_next  = lensum_reg;
        idxlen_next  = idxlen_reg;
        rbits_next   = rbits_reg;
        bv_next      = bv_reg;
        acc_next     = acc_reg;
        row_next     = row_reg;
        sum_next     = sum_reg;
        bitsum_next  = bitsum_reg;
        mside_next   = mside_reg;
        best_next    = best_reg;
        seca_next    = seca_reg;
        o_start_next = o_start_reg;
        o_len_next   = o_len_reg;
        o_book_next  = o_book_reg;
        o_hb_next    = o_hb_reg;
        o_side_next  = o_side_reg;
        o_last_next  = o_last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_last_next  = m_last_reg;
        m_data_next  = m_data_reg;

        load_ready = 1'b0;
        tbl_raddr  = i_reg[AW-1:0];
        work_we    = 1'b0;
        work_wa    = s_reg[AW-1:0];
        work_wd    = acc_reg;
        sec_we     = 1'b0;
        sec_wa     = s_reg[AW-1:0];
        sec_wd     = '0;
        start_we   = 1'b0;
        start_wa   = '0;
        start_wd   = s_reg[AW-1:0];
        work_ra0   = '0;
        work_ra1   = '0;
        sec_ra0    = '0;
        sec_ra1    = '0;
        start_ra   = '0;

        case (state_reg)
            LOAD: begin
                load_ready = 1'b1;
                if (load_last) begin
                    nn = (cfg.band_count > LEN_W'(MAX_BANDS)) ? NW'(MAX_BANDS)
                                                              : cfg.band_count[NW-1:0];
                    if (nn != '0) begin
                        n_next     = nn;
                        i_next     = '0;
                        state_next = I_RD;
                    end
                end
            end
            I_RD: begin
                tbl_raddr  = i_reg[AW-1:0];
                state_next = I_BEST;
            end
            I_BEST: begin
                pk         = best_of(widen(tbl_rdata), lim);
                bv_next    = pk.val;
                bb_next    = pk.book;
                row_next   = tbl_rdata;
                state_next = I_RUN;
            end
            I_RUN: begin
                if (i_reg == '0 || bb_reg != rbook_reg) begin
                    if (i_reg != '0) begin
                        im1      = i_reg - NW'(1);
                        t17      = GAIN_W'(rbits_reg) + GAIN_W'(side_bits(rlen_reg,
                                                                      cfg.short_blk));
                        work_we  = 1'b1;
                        sec_we   = 1'b1;
                        sec_wd   = '{len: rlen_reg,
                                     bits: t17[GAIN_W-1] ? '1 : t17[BITS_W-1:0],
                                     gain: '0};
                        start_we = 1'b1;
                        start_wa = im1[AW-1:0];
                    end
                    s_next     = i_reg;
                    rbook_next = bb_reg;
                    rlen_next  = LEN_W'(1);
                    rbits_next = bv_reg;
                    acc_next   = row_reg;
                end else begin
                    t17        = GAIN_W'(rbits_reg) + GAIN_W'(bv_reg);
                    rlen_next  = rlen_reg + LEN_W'(1);
                    rbits_next = t17[GAIN_W-1] ? '1 : t17[BITS_W-1:0];
                    acc_next   = merge_row(acc_reg, row_reg, cfg.invalid_bitcount);
                end
                i_next     = i_reg + NW'(1);
                state_next = (i_reg + NW'(1) == n_reg) ? I_CLOSE : I_RD;
            end
            I_CLOSE: begin
                im1      = n_reg - NW'(1);
                t17      = GAIN_W'(rbits_reg) + GAIN_W'(side_bits(rlen_reg, cfg.short_blk));
                work_we  = 1'b1;
                sec_we   = 1'b1;
                sec_wd   = '{len: rlen_reg,
                             bits: t17[GAIN_W-1] ? '1 : t17[BITS_W-1:0],
                             gain: '0};
                start_we = 1'b1;
                start_wa = im1[AW-1:0];
                i_next     = '0;
                state_next = G_RD;
            end
            G_RD: begin
                sec_ra0    = i_reg[AW-1:0];
                state_next = G_CHK;
            end
            G_CHK: begin
                bsum = SUM_W'(i_reg) + SUM_W'(sec_rd0.len);
                if (bsum >= SUM_W'(n_reg)) begin
                    state_next = M_START;
                end else begin
                    a_next     = i_reg;
                    b_next     = bsum[NW-1:0];
                    ret_next   = G_NEXT;
                    state_next = PG_RD;
                end
            end
            G_NEXT: begin
                i_next     = b_reg;
                state_next = G_RD;
            end
            PG_RD: begin
                work_ra0   = a_reg[AW-1:0];
                work_ra1   = b_reg[AW-1:0];
                sec_ra0    = a_reg[AW-1:0];
                sec_ra1    = b_reg[AW-1:0];
                state_next = PG_SUM;
            end
            PG_SUM: begin
                for (int j = 0; j < NUM_BOOKS; j++) begin
                    sum_next[j] = BITS_W'(work_rd0[j]) + BITS_W'(work_rd1[j]);
                end
                lensum_next = sec_rd0.len + sec_rd1.len;
                bitsum_next = GAIN_W'(sec_rd0.bits) + GAIN_W'(sec_rd1.bits);
                seca_next   = sec_rd0;
                state_next  = PG_MIN;
            end
            PG_MIN: begin
                pk         = best_of(sum_reg, lim);
                mside_next = GAIN_W'(pk.val) + GAIN_W'(side_bits(lensum_reg, cfg.short_blk));
                state_next = PG_GAIN;
            end
            PG_GAIN: begin
                t19 = $signed({2'b00, bitsum_reg}) - $signed({2'b00, mside_reg});
                if (t19 > 19'sd65535) begin
                    t17 = GAIN_W'(17'h0FFFF);
                end else if (t19 < -19'sd65536) begin
                    t17 = GAIN_W'(17'h10000);
                end else begin
                    t17 = t19[GAIN_W-1:0];
                end
                sec_we     = 1'b1;
                sec_wa     = a_reg[AW-1:0];
                sec_wd     = '{len: seca_reg.len, bits: seca_reg.bits, gain: t17};
                state_next = ret_reg;
            end
            M_START: begin
                i_next     = '0;
                best_next  = '0;
                idx_next   = '0;
                state_next = M_RD;
            end
            M_RD: begin
                sec_ra0    = i_reg[AW-1:0];
                state_next = M_CHK;
            end
            M_CHK: begin
                bsum = SUM_W'(i_reg) + SUM_W'(sec_rd0.len);
                if (bsum < SUM_W'(n_reg)) begin
                    if ($signed(sec_rd0.gain) > $signed(best_reg)) begin
                        best_next   = sec_rd0.gain;
                        idx_next    = i_reg;
                        idxlen_next = sec_rd0.len;
                    end
                    i_next     = bsum[NW-1:0];
                    state_next = M_RD;
                end else if (best_reg != '0) begin
                    bsum       = SUM_W'(idx_reg) + SUM_W'(idxlen_reg);
                    nxt_next   = bsum[NW-1:0];
                    state_next = X_RD;
                end else begin
                    i_next     = '0;
                    state_next = O_RD;
                end
            end
            X_RD: begin
                work_ra0   = idx_reg[AW-1:0];
                work_ra1   = nxt_reg[AW-1:0];
                sec_ra0    = idx_reg[AW-1:0];
                sec_ra1    = nxt_reg[AW-1:0];
                state_next = X_UPD;
            end
            X_UPD: begin
                ln  = sec_rd0.len + sec_rd1.len;
                t19 = $signed({3'b000, sec_rd0.bits}) + $signed({3'b000, sec_rd1.bits})
                      - $signed({2'b00, best_reg});
                work_we = 1'b1;
                work_wa = idx_reg[AW-1:0];
                work_wd = merge_row(work_rd0, work_rd1, cfg.invalid_bitcount);
                sec_we  = 1'b1;
                sec_wa  = idx_reg[AW-1:0];
                sec_wd  = '{len: ln,
                            bits: (t19 < 19'sd0) ? '0 :
                                  (t19 > 19'sd65535) ? '1 : t19[BITS_W-1:0],
                            gain: sec_rd0.gain};
                bsum       = SUM_W'(idx_reg) + SUM_W'(ln);
                nxt2_next  = bsum[NW-1:0];
                state_next = (idx_reg != '0) ? X_PRD : X_TAIL;
            end
            X_PRD: begin
                im1        = idx_reg - NW'(1);
                start_ra   = im1[AW-1:0];
                state_next = X_PWAIT;
            end
            X_PWAIT: begin
                a_next     = NW'(start_rd);
                b_next     = idx_reg;
                ret_next   = X_TAIL;
                state_next = PG_RD;
            end
            X_TAIL: begin
                im1      = nxt2_reg - NW'(1);
                start_we = 1'b1;
                start_wa = im1[AW-1:0];
                start_wd = idx_reg[AW-1:0];
                if (nxt2_reg < n_reg) begin
                    a_next     = idx_reg;
                    b_next     = nxt2_reg;
                    ret_next   = M_START;
                    state_next = PG_RD;
                end else begin
                    state_next = M_START;
                end
            end
            O_RD: begin
                sec_ra0    = i_reg[AW-1:0];
                work_ra0   = i_reg[AW-1:0];
                state_next = O_CALC;
            end
            O_CALC: begin
                pk  = best_of(widen(work_rd0), lim);
                sd  = side_bits(sec_rd0.len, cfg.short_blk);
                t18 = $signed({2'b00, sec_rd0.bits}) - $signed({10'd0, sd});
                o_hb_next    = (t18 < 18'sd0) ? '0 :
                               (t18 > 18'sd32767) ? '1 : t18[CNT_W-1:0];
                o_start_next = BAND_W'(i_reg);
                o_len_next   = sec_rd0.len;
                o_book_next  = pk.book;
                o_side_next  = sd;
                bsum         = SUM_W'(i_reg) + SUM_W'(sec_rd0.len);
                o_last_next  = (bsum >= SUM_W'(n_reg));
                b_next       = bsum[NW-1:0];
                state_next   = O_EMIT;
            end
            O_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_last_next  = o_last_reg;
                    m_data_next  = {o_side_reg, o_hb_reg, o_book_reg, o_len_reg, o_start_reg};
                    if (o_last_reg) begin
                        state_next = LOAD;
                    end else begin
                        i_next     = b_reg;
                        state_next = O_RD;
                    end
                end
            end
            default: begin
                state_next = LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        ret_reg     <= ret_next;
        n_reg       <= n_next;
        i_reg       <= i_next;
        s_reg       <= s_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        idx_reg     <= idx_next;
        nxt_reg     <= nxt_next;
        nxt2_reg    <= nxt2_next;
        rbook_reg   <= rbook_next;
        bb_reg      <= bb_next;
        rlen_reg    <= rlen_next;
        lensum_reg  <= lensum_next;
        idxlen_reg  <= idxlen_next;
        rbits_reg   <= rbits_next;
        bv_reg      <= bv_next;
        acc_reg     <= acc_next;
        row_reg     <= row_next;
        sum_reg     <= sum_next;
        bitsum_reg  <= bitsum_next;
        mside_reg   <= mside_next;
        best_reg    <= best_next;
        seca_reg    <= seca_next;
        o_start_reg <= o_start_next;
        o_len_reg   <= o_len_next;
        o_book_reg  <= o_book_next;
        o_hb_reg    <= o_hb_next;
        o_side_reg  <= o_side_next;
        o_last_reg  <= o_last_next;
        m_last_reg  <= m_last_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_run_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == I_RUN) |-> (i_reg < n_reg))
        else $error("band index past group end");

    a_start_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        start_we |-> (NW'(start_wa) < n_reg))
        else $error("start store write outside group");

    a_best_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == M_CHK) |-> !best_reg[GAIN_W-1])
        else $error("negative best gain");

    a_emit_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == O_EMIT) |-> (o_len_reg != '0))
        else $error("empty section emitted");

endmodule
